FILE: design/assert_macros.svh
// Assertion macros shared by the frame parser RTL.
// Needs nothing else; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define UFP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame parser assertion failed");

// Next-cycle implication, disabled while reset is high.
`define UFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame parser assertion failed");

// Next-cycle implication that also holds across reset.
`define UFP_ASSERT_NEXT_ANY(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("frame parser assertion failed");

`endif

FILE: design/ufp_pkg.sv
// Shared types and constants of the UBX frame parser.
// No dependencies; used by every module of the block.
package ufp_pkg;

  localparam logic [7:0]  SYNC_A         = 8'hB5;
  localparam logic [7:0]  SYNC_B         = 8'h62;
  localparam logic [7:0]  FIX_3D         = 8'h03;

  // Message keys: class in the low byte, id in the high byte.
  localparam logic [15:0] ID_POSLLH      = 16'h0201;
  localparam logic [15:0] ID_TIMEUTC     = 16'h2101;
  localparam logic [15:0] ID_STATUS      = 16'h0301;
  localparam logic [15:0] ID_ACK         = 16'h0105;
  localparam logic [15:0] ID_NAK         = 16'h0005;

  localparam logic [16:0] FRAME_OVERHEAD = 17'd8;
  localparam logic [15:0] MAX_LEN_RESET  = 16'd255;

  // Payload offsets of the last byte of each latched field.
  localparam logic [15:0] OFS_LON_END    = 16'd7;
  localparam logic [15:0] OFS_LAT_END    = 16'd11;
  localparam logic [15:0] OFS_NANO_END   = 16'd11;
  localparam logic [15:0] OFS_DATE_END   = 16'd15;
  localparam logic [15:0] OFS_CLOCK_END  = 16'd18;
  localparam logic [15:0] OFS_FIX        = 16'd4;
  localparam logic [15:0] OFS_ACK_END    = 16'd1;

  localparam logic        STATUS_DONE    = 1'b0;
  localparam logic        STATUS_DROPPED = 1'b1;

  // Register index taken from paddr[2].
  localparam logic        REG_MAX_FRAME_LENGTH = 1'b0;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int RES_DEPTH   = 2;
  localparam int RPTR_W      = $clog2(RES_DEPTH);

  typedef struct packed {
    logic [7:0] data;
    logic       flush;
    logic       sync_a;
    logic       sync_b;
    logic       fix_3d;
  } ufp_item_t;

  typedef struct packed {
    logic [7:0]         msg_class;
    logic [7:0]         msg_ident;
    logic [15:0]        payload_length;
    logic               is_nav;
    logic               status;
    logic signed [31:0] longitude;
    logic signed [31:0] latitude;
    logic               fix_good;
    logic [15:0]        acked_message;
    logic signed [31:0] utc_nanoseconds;
    logic [31:0]        utc_date;
    logic [23:0]        utc_time;
  } ufp_result_t;

  typedef struct packed {
    logic take;
    logic emit;
  } ufp_back_status_t;

endpackage

FILE: design/ufp_front.sv
// Front end of the frame parser: accepts bytes and classifies them.
// Depends on ufp_pkg.
module ufp_front (
  input  logic             push,
  input  logic             full,
  input  logic [7:0]       rx_byte,
  input  logic             flush,
  output logic             wr_en,
  output ufp_pkg::ufp_item_t item
);

  assign wr_en       = push && !full;
  assign item.data   = rx_byte;
  assign item.flush  = flush;
  assign item.sync_a = (rx_byte == ufp_pkg::SYNC_A);
  assign item.sync_b = (rx_byte == ufp_pkg::SYNC_B);
  assign item.fix_3d = (rx_byte == ufp_pkg::FIX_3D);

endmodule

FILE: design/ufp_item_queue.sv
// Short queue of classified bytes between front and back end.
// Depends on ufp_pkg.
module ufp_item_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  ufp_pkg::ufp_item_t wr_item,
  output logic               full,
  output logic               rd_valid,
  output ufp_pkg::ufp_item_t rd_item,
  input  logic               rd_take
);

  ufp_pkg::ufp_item_t             entries [ufp_pkg::QUEUE_DEPTH];
  logic [ufp_pkg::QPTR_W-1:0]     wr_ptr;
  logic [ufp_pkg::QPTR_W-1:0]     rd_ptr;
  logic [ufp_pkg::QPTR_W:0]       count;

  assign full     = (count == (ufp_pkg::QPTR_W+1)'(ufp_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/ufp_back.sv
// Back end of the frame parser: frame state machine, field latches and result queue.
// Depends on ufp_pkg.
module ufp_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [15:0]               max_frame_length,
  input  logic                      in_valid,
  input  ufp_pkg::ufp_item_t        in_item,
  input  logic                      pop,
  output logic                      empty,
  output ufp_pkg::ufp_result_t      result,
  output ufp_pkg::ufp_back_status_t status
);

  typedef enum logic [7:0] {
    PH_SYNC1 = 8'b0000_0001,
    PH_SYNC2 = 8'b0000_0010,
    PH_CLASS = 8'b0000_0100,
    PH_IDENT = 8'b0000_1000,
    PH_LENLO = 8'b0001_0000,
    PH_LENHI = 8'b0010_0000,
    PH_PAYLD = 8'b0100_0000,
    PH_CKSUM = 8'b1000_0000
  } ufp_phase_t;

  ufp_phase_t  phase, phase_next;
  logic [15:0] byte_counter, byte_counter_next;
  logic [15:0] length_held, length_held_next;
  logic [7:0]  class_held, class_held_next;
  logic [7:0]  ident_held, ident_held_next;
  logic [31:0] capture_shift, capture_shift_next;
  logic [31:0] longitude_held, longitude_held_next;
  logic [31:0] latitude_held, latitude_held_next;
  logic        fix_held, fix_held_next;
  logic [15:0] ack_held, ack_held_next;
  logic [31:0] nano_held, nano_held_next;
  logic [31:0] date_held, date_held_next;
  logic [23:0] clock_held, clock_held_next;

  logic [15:0] key;
  logic [15:0] new_length;
  logic [16:0] total_length;
  logic [16:0] idx_plus_one;
  logic [31:0] shifted;
  logic        take;
  logic        emit;
  logic        emit_status;

  ufp_pkg::ufp_result_t      res_entries [ufp_pkg::RES_DEPTH];
  ufp_pkg::ufp_result_t      res_new;
  logic [ufp_pkg::RPTR_W-1:0] res_wr_ptr;
  logic [ufp_pkg::RPTR_W-1:0] res_rd_ptr;
  logic [ufp_pkg::RPTR_W:0]   res_count;
  logic                       res_pop;

  assign key          = {ident_held, class_held};
  assign new_length   = {in_item.data, length_held[7:0]};
  assign total_length = {1'b0, new_length} + ufp_pkg::FRAME_OVERHEAD;
  assign idx_plus_one = {1'b0, byte_counter} + 17'd1;
  assign shifted      = {in_item.data, capture_shift[31:8]};

  // Take an item only while the result queue has room for what it may cause.
  assign take    = in_valid && (res_count != (ufp_pkg::RPTR_W+1)'(ufp_pkg::RES_DEPTH));
  assign res_pop = pop && !empty;
  assign empty   = (res_count == '0);
  assign result  = res_entries[res_rd_ptr];

  assign status.take = take;
  assign status.emit = emit;

  always_comb begin
    phase_next          = phase;
    byte_counter_next   = byte_counter;
    length_held_next    = length_held;
    class_held_next     = class_held;
    ident_held_next     = ident_held;
    capture_shift_next  = capture_shift;
    longitude_held_next = longitude_held;
    latitude_held_next  = latitude_held;
    fix_held_next       = fix_held;
    ack_held_next       = ack_held;
    nano_held_next      = nano_held;
    date_held_next      = date_held;
    clock_held_next     = clock_held;
    emit                = 1'b0;
    emit_status         = ufp_pkg::STATUS_DONE;

    if (take) begin
      if (in_item.flush) begin
        phase_next        = PH_SYNC1;
        byte_counter_next = '0;
      end else begin
        unique case (phase)
          PH_SYNC1: begin
            if (in_item.sync_a) phase_next = PH_SYNC2;
          end
          PH_SYNC2: begin
            if (in_item.sync_b) phase_next = PH_CLASS;
            else if (!in_item.sync_a) phase_next = PH_SYNC1;
          end
          PH_CLASS: begin
            class_held_next = in_item.data;
            phase_next      = PH_IDENT;
          end
          PH_IDENT: begin
            ident_held_next = in_item.data;
            phase_next      = PH_LENLO;
          end
          PH_LENLO: begin
            length_held_next = {8'h00, in_item.data};
            phase_next       = PH_LENHI;
          end
          PH_LENHI: begin
            length_held_next   = new_length;
            byte_counter_next  = '0;
            capture_shift_next = '0;
            if (total_length > {1'b0, max_frame_length}) begin
              // Drop the oversize frame and restart the hunt right away.
              phase_next  = PH_SYNC1;
              emit        = 1'b1;
              emit_status = ufp_pkg::STATUS_DROPPED;
            end else if (new_length == '0) begin
              phase_next = PH_CKSUM;
            end else begin
              phase_next = PH_PAYLD;
            end
          end
          PH_PAYLD: begin
            capture_shift_next = shifted;
            case (key) inside
              ufp_pkg::ID_POSLLH: begin
                if (byte_counter == ufp_pkg::OFS_LON_END) longitude_held_next = shifted;
                if (byte_counter == ufp_pkg::OFS_LAT_END) latitude_held_next = shifted;
              end
              ufp_pkg::ID_TIMEUTC: begin
                if (byte_counter == ufp_pkg::OFS_NANO_END) nano_held_next = shifted;
                if (byte_counter == ufp_pkg::OFS_DATE_END) date_held_next = shifted;
                if (byte_counter == ufp_pkg::OFS_CLOCK_END) clock_held_next = shifted[31:8];
              end
              ufp_pkg::ID_STATUS: begin
                if (byte_counter == ufp_pkg::OFS_FIX) fix_held_next = in_item.fix_3d;
              end
              ufp_pkg::ID_ACK, ufp_pkg::ID_NAK: begin
                if (byte_counter == ufp_pkg::OFS_ACK_END) ack_held_next = shifted[31:16];
              end
              default: begin
              end
            endcase
            if (idx_plus_one >= {1'b0, length_held}) begin
              phase_next        = PH_CKSUM;
              byte_counter_next = '0;
            end else begin
              byte_counter_next = idx_plus_one[15:0];
            end
          end
          PH_CKSUM: begin
            if (byte_counter == '0) begin
              byte_counter_next = 16'd1;
            end else begin
              byte_counter_next = '0;
              phase_next        = PH_SYNC1;
              emit              = 1'b1;
            end
          end
          default: begin
            phase_next = PH_SYNC1;
          end
        endcase
      end
    end
  end

  always_comb begin
    res_new.msg_class       = class_held_next;
    res_new.msg_ident       = ident_held_next;
    res_new.payload_length  = length_held_next;
    res_new.is_nav          = (key == ufp_pkg::ID_POSLLH) || (key == ufp_pkg::ID_TIMEUTC);
    res_new.status          = emit_status;
    res_new.longitude       = longitude_held_next;
    res_new.latitude        = latitude_held_next;
    res_new.fix_good        = fix_held_next;
    res_new.acked_message   = ack_held_next;
    res_new.utc_nanoseconds = nano_held_next;
    res_new.utc_date        = date_held_next;
    res_new.utc_time        = clock_held_next;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_entries[res_wr_ptr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SYNC1;
      byte_counter   <= '0;
      length_held    <= '0;
      class_held     <= '0;
      ident_held     <= '0;
      capture_shift  <= '0;
      longitude_held <= '0;
      latitude_held  <= '0;
      fix_held       <= 1'b0;
      ack_held       <= '0;
      nano_held      <= '0;
      date_held      <= '0;
      clock_held     <= '0;
      res_wr_ptr     <= '0;
      res_rd_ptr     <= '0;
      res_count      <= '0;
    end else begin
      phase          <= phase_next;
      byte_counter   <= byte_counter_next;
      length_held    <= length_held_next;
      class_held     <= class_held_next;
      ident_held     <= ident_held_next;
      capture_shift  <= capture_shift_next;
      longitude_held <= longitude_held_next;
      latitude_held  <= latitude_held_next;
      fix_held       <= fix_held_next;
      ack_held       <= ack_held_next;
      nano_held      <= nano_held_next;
      date_held      <= date_held_next;
      clock_held     <= clock_held_next;
      if (emit) begin
        res_wr_ptr <= res_wr_ptr + 1'b1;
      end
      if (res_pop) begin
        res_rd_ptr <= res_rd_ptr + 1'b1;
      end
      case ({emit, res_pop})
        2'b10:   res_count <= res_count + 1'b1;
        2'b01:   res_count <= res_count - 1'b1;
        default: res_count <= res_count;
      endcase
    end
  end

endmodule

FILE: design/ubx_frame_parser_unit.sv
// Top level of the UBX frame parser: register port, front end, byte queue, back end.
// Depends on ufp_pkg, ufp_front, ufp_item_queue, ufp_back and assert_macros.svh.
//
// Use: push one UART byte per transfer on rx_byte while full is low; raise flush
// with a transfer to abandon a partial frame (that byte is ignored). Each finished
// frame, and each frame dropped for exceeding max_frame_length, yields one result
// transfer: read the fields while empty is low and raise pop to take it.
// Throughput: one byte per cycle while the result queue has room, set by the
// single-byte step of the back-end state machine. A result passes two registers:
// the byte that completes it is written into the 4-entry byte queue, and the edge
// that takes it from there writes the 2-entry result queue, where it waits for pop.
// Stall: when the receiver holds off pop and the result queue is full, the back
// end stops taking bytes; the byte queue then fills and full rises. Bytes that
// cause no result still pass while one result waits.
// Reset (rst, synchronous): both queues empty, parser hunts for the first sync
// byte, all latched fields zero, max_frame_length back to 255.
// Register: max_frame_length at byte address 0 over the APB-style port; write it
// only while the block is idle. pready is always high.
`include "assert_macros.svh"

module ubx_frame_parser_unit (
  input  logic               clk,
  input  logic               rst,
  // byte channel
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte,
  input  logic               flush,
  // result channel
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         msg_class,
  output logic [7:0]         msg_ident,
  output logic [15:0]        payload_length,
  output logic               is_nav,
  output logic               status,
  output logic signed [31:0] longitude,
  output logic signed [31:0] latitude,
  output logic               fix_good,
  output logic [15:0]        acked_message,
  output logic signed [31:0] utc_nanoseconds,
  output logic [31:0]        utc_date,
  output logic [23:0]        utc_time,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [15:0]                max_frame_length;
  logic                       cfg_write;
  logic                       q_wr_en;
  ufp_pkg::ufp_item_t         q_wr_item;
  logic                       q_valid;
  ufp_pkg::ufp_item_t         q_item;
  ufp_pkg::ufp_result_t       res;
  ufp_pkg::ufp_back_status_t  back_status;

  // Register port: paddr[2] picks the register. Writes ignore the low address
  // bits; a read at a nonzero byte offset returns zero.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == ufp_pkg::REG_MAX_FRAME_LENGTH) && (paddr[1:0] == 2'b00)
                     ? {16'h0000, max_frame_length} : 32'h0000_0000;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= ufp_pkg::MAX_LEN_RESET;
    end else if (cfg_write && (paddr[2] == ufp_pkg::REG_MAX_FRAME_LENGTH)) begin
      max_frame_length <= pwdata[15:0];
    end
  end

  // Accept and classify bytes.
  ufp_front u_front (
    .push    (push),
    .full    (full),
    .rx_byte (rx_byte),
    .flush   (flush),
    .wr_en   (q_wr_en),
    .item    (q_wr_item)
  );

  // Decouple the front from the parser so either side can stall.
  ufp_item_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_wr_en),
    .wr_item  (q_wr_item),
    .full     (full),
    .rd_valid (q_valid),
    .rd_item  (q_item),
    .rd_take  (back_status.take)
  );

  // Parse frames, latch fields, hold results until popped.
  ufp_back u_back (
    .clk              (clk),
    .rst              (rst),
    .max_frame_length (max_frame_length),
    .in_valid         (q_valid),
    .in_item          (q_item),
    .pop              (pop),
    .empty            (empty),
    .result           (res),
    .status           (back_status)
  );

  assign msg_class       = res.msg_class;
  assign msg_ident       = res.msg_ident;
  assign payload_length  = res.payload_length;
  assign is_nav          = res.is_nav;
  assign status          = res.status;
  assign longitude       = res.longitude;
  assign latitude        = res.latitude;
  assign fix_good        = res.fix_good;
  assign acked_message   = res.acked_message;
  assign utc_nanoseconds = res.utc_nanoseconds;
  assign utc_date        = res.utc_date;
  assign utc_time        = res.utc_time;

  // A byte that enters the queue is visible to the back end next cycle.
  `UFP_ASSERT_NEXT(a_push_reaches_back, clk, rst, push && !full && !rst, q_valid)
  // The back end never takes from an empty queue.
  `UFP_ASSERT_NOW(a_take_needs_item, clk, rst, back_status.take, q_valid)
  // A produced result is offered on the next cycle.
  `UFP_ASSERT_NEXT(a_emit_offered, clk, rst, back_status.emit && !rst, !empty)
  // Reset leaves no result pending.
  `UFP_ASSERT_NEXT_ANY(a_reset_empty, clk, rst, empty)

endmodule

FILE: verif/ubx_frame_parser_unit_tb.sv
// Self-checking testbench of the UBX frame parser: byte stream in, frame results out.
// Depends on ufp_pkg and ubx_frame_parser_unit; predicts every frame result on its own.
// Directed frames come first, then random traffic under several length limits.
module ubx_frame_parser_unit_tb;

  // Register byte addresses; only index 0 exists, index 1 must be ignored.
  localparam logic [2:0] LIMIT_ADDR = 3'd0;
  localparam logic [2:0] SPARE_ADDR = 3'd4;
  localparam int         DRAIN_TAIL = 12;
  localparam int         DRAIN_CAP  = 5000;

  typedef enum logic [2:0] {
    HUNT_SYNC_A, HUNT_SYNC_B, TAKE_CLASS, TAKE_IDENT,
    TAKE_LEN_LO, TAKE_LEN_HI, TAKE_PAYLOAD, TAKE_CHECKSUM
  } parse_step_t;

  typedef struct packed {
    logic [7:0] data;
    logic       flush;
  } byte_slot_t;

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               push    = 1'b0;
  logic [7:0]         rx_byte = 8'h00;
  logic               flush   = 1'b0;
  logic               pop     = 1'b0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [2:0]         paddr   = 3'd0;
  logic [31:0]        pwdata  = 32'h0;
  logic               full;
  logic               empty;
  logic [7:0]         msg_class;
  logic [7:0]         msg_ident;
  logic [15:0]        payload_length;
  logic               is_nav;
  logic               status;
  logic signed [31:0] longitude;
  logic signed [31:0] latitude;
  logic               fix_good;
  logic [15:0]        acked_message;
  logic signed [31:0] utc_nanoseconds;
  logic [31:0]        utc_date;
  logic [23:0]        utc_time;
  logic [31:0]        prdata;
  logic               pready;

  ubx_frame_parser_unit DUT (
    .clk, .rst,
    .push, .full, .rx_byte, .flush,
    .empty, .pop, .msg_class, .msg_ident, .payload_length, .is_nav, .status,
    .longitude, .latitude, .fix_good, .acked_message,
    .utc_nanoseconds, .utc_date, .utc_time,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bytes waiting to be pushed, and frame results waiting to be popped.
  byte_slot_t           byte_backlog[$];
  ufp_pkg::ufp_result_t frames_due[$];
  ufp_pkg::ufp_result_t want_frame;

  int send_idle_pct  = 21;
  int recv_idle_pct  = 73;
  int mismatch_count = 0;
  int bytes_added    = 0;
  int frames_added   = 0;

  // Parser copy, updated on every byte transfer.
  logic [15:0] frame_limit = ufp_pkg::MAX_LEN_RESET;
  parse_step_t parse_at    = HUNT_SYNC_A;
  logic [15:0] byte_count  = '0;
  logic [15:0] len_q       = '0;
  logic [7:0]  cls_q       = '0;
  logic [7:0]  id_q        = '0;
  logic [31:0] shift_q     = '0;
  logic [31:0] lon_q       = '0;
  logic [31:0] lat_q       = '0;
  logic        fix_q       = 1'b0;
  logic [15:0] ack_q       = '0;
  logic [31:0] nano_q      = '0;
  logic [31:0] date_q      = '0;
  logic [23:0] clock_q     = '0;

  task automatic log_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      log_mismatch($sformatf("%s got %h, expected %h", name, got, want));
  endtask

  function automatic void queue_frame_result(input logic st);
    ufp_pkg::ufp_result_t r;
    logic [15:0] key;
    key = {id_q, cls_q};
    r.msg_class       = cls_q;
    r.msg_ident       = id_q;
    r.payload_length  = len_q;
    r.is_nav          = (key == ufp_pkg::ID_POSLLH) || (key == ufp_pkg::ID_TIMEUTC);
    r.status          = st;
    r.longitude       = lon_q;
    r.latitude        = lat_q;
    r.fix_good        = fix_q;
    r.acked_message   = ack_q;
    r.utc_nanoseconds = nano_q;
    r.utc_date        = date_q;
    r.utc_time        = clock_q;
    frames_due.push_back(r);
  endfunction

  function automatic void advance_parser(input logic [7:0] b, input logic fl);
    logic [15:0] key;
    logic [15:0] idx;
    key = {id_q, cls_q};
    idx = byte_count;
    if (fl) begin
      // Abandon the partial frame; latches already written stay written.
      parse_at   = HUNT_SYNC_A;
      byte_count = '0;
      return;
    end
    case (parse_at)
      HUNT_SYNC_A: if (b == ufp_pkg::SYNC_A) parse_at = HUNT_SYNC_B;
      HUNT_SYNC_B: begin
        if (b == ufp_pkg::SYNC_B) parse_at = TAKE_CLASS;
        else if (b != ufp_pkg::SYNC_A) parse_at = HUNT_SYNC_A;
      end
      TAKE_CLASS: begin
        cls_q    = b;
        parse_at = TAKE_IDENT;
      end
      TAKE_IDENT: begin
        id_q     = b;
        parse_at = TAKE_LEN_LO;
      end
      TAKE_LEN_LO: begin
        len_q    = {8'h00, b};
        parse_at = TAKE_LEN_HI;
      end
      TAKE_LEN_HI: begin
        len_q[15:8] = b;
        byte_count  = '0;
        shift_q     = '0;
        // Compare at 17 bits so the overhead never wraps.
        if ({1'b0, len_q} + ufp_pkg::FRAME_OVERHEAD > {1'b0, frame_limit}) begin
          parse_at = HUNT_SYNC_A;
          queue_frame_result(ufp_pkg::STATUS_DROPPED);
        end else begin
          parse_at = (len_q == 16'd0) ? TAKE_CHECKSUM : TAKE_PAYLOAD;
        end
      end
      TAKE_PAYLOAD: begin
        shift_q = {b, shift_q[31:8]};
        if (key == ufp_pkg::ID_POSLLH) begin
          if (idx == ufp_pkg::OFS_LON_END) lon_q = shift_q;
          if (idx == ufp_pkg::OFS_LAT_END) lat_q = shift_q;
        end else if (key == ufp_pkg::ID_TIMEUTC) begin
          if (idx == ufp_pkg::OFS_NANO_END)  nano_q  = shift_q;
          if (idx == ufp_pkg::OFS_DATE_END)  date_q  = shift_q;
          if (idx == ufp_pkg::OFS_CLOCK_END) clock_q = shift_q[31:8];
        end else if (key == ufp_pkg::ID_STATUS) begin
          if (idx == ufp_pkg::OFS_FIX) fix_q = (b == ufp_pkg::FIX_3D);
        end else if (key == ufp_pkg::ID_ACK || key == ufp_pkg::ID_NAK) begin
          if (idx == ufp_pkg::OFS_ACK_END) ack_q = shift_q[31:16];
        end
        if ({1'b0, idx} + 17'd1 >= {1'b0, len_q}) begin
          parse_at   = TAKE_CHECKSUM;
          byte_count = '0;
        end else begin
          byte_count = idx + 16'd1;
        end
      end
      default: begin
        // Two checksum bytes, counted but never verified.
        if (byte_count == 16'd0) begin
          byte_count = 16'd1;
        end else begin
          byte_count = '0;
          parse_at   = HUNT_SYNC_A;
          queue_frame_result(ufp_pkg::STATUS_DONE);
        end
      end
    endcase
  endfunction

  // Driver: retire the byte that transferred, then offer the next one or idle.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        advance_parser(rx_byte, flush);
        void'(byte_backlog.pop_front());
      end
      if (byte_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        push    <= 1'b1;
        rx_byte <= byte_backlog[0].data;
        flush   <= byte_backlog[0].flush;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: check each result transfer against the oldest predicted frame.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (frames_due.size() == 0) begin
          log_mismatch("result transfer with no frame waiting");
        end else begin
          want_frame = frames_due.pop_front();
          check_field("msg_class", msg_class, want_frame.msg_class);
          check_field("msg_ident", msg_ident, want_frame.msg_ident);
          check_field("payload_length", payload_length, want_frame.payload_length);
          check_field("is_nav", is_nav, want_frame.is_nav);
          check_field("status", status, want_frame.status);
          check_field("longitude", longitude, want_frame.longitude);
          check_field("latitude", latitude, want_frame.latitude);
          check_field("fix_good", fix_good, want_frame.fix_good);
          check_field("acked_message", acked_message, want_frame.acked_message);
          check_field("utc_nanoseconds", utc_nanoseconds, want_frame.utc_nanoseconds);
          check_field("utc_date", utc_date, want_frame.utc_date);
          check_field("utc_time", utc_time, want_frame.utc_time);
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic void add_byte(input logic [7:0] b, input logic fl);
    byte_slot_t s;
    s.data  = b;
    s.flush = fl;
    byte_backlog.push_back(s);
    bytes_added++;
  endfunction

  // Queue one frame; a nonzero cut below the frame's size stops after that many bytes and flushes.
  function automatic void add_frame(input logic [15:0] key, input logic [15:0] len,
                                    input int cut);
    logic [7:0] img[$];
    int stop;
    img.push_back(ufp_pkg::SYNC_A);  img.push_back(ufp_pkg::SYNC_B);
    img.push_back(key[7:0]);         img.push_back(key[15:8]);
    img.push_back(len[7:0]);         img.push_back(len[15:8]);
    if ({1'b0, len} + ufp_pkg::FRAME_OVERHEAD > {1'b0, frame_limit}) begin
      // Dropped after the header: trail some junk the hunter has to chew through.
      repeat ($urandom_range(0, 3)) img.push_back(8'($urandom_range(0, 255)));
    end else begin
      for (int i = 0; i < len; i++) begin
        if (key == ufp_pkg::ID_STATUS && i == ufp_pkg::OFS_FIX && $urandom_range(0, 1) == 1)
          img.push_back(ufp_pkg::FIX_3D);
        else
          img.push_back(8'($urandom_range(0, 255)));
      end
      img.push_back(8'($urandom_range(0, 255)));
      img.push_back(8'($urandom_range(0, 255)));
    end
    stop = (cut > 0 && cut < img.size()) ? cut : img.size();
    for (int i = 0; i < stop; i++) add_byte(img[i], 1'b0);
    if (stop < img.size()) add_byte(8'($urandom_range(0, 255)), 1'b1);
    else frames_added++;
  endfunction

  // Mostly well-formed frames of the latched message kinds, plus noise and flushes.
  function automatic void add_random_traffic(input int byte_goal, input int frame_goal);
    logic [15:0] key;
    logic [15:0] len;
    int pick;
    int lo;
    bytes_added  = 0;
    frames_added = 0;
    while (bytes_added < byte_goal || frames_added < frame_goal) begin
      case ($urandom_range(0, 5))
        0:       key = ufp_pkg::ID_POSLLH;
        1:       key = ufp_pkg::ID_TIMEUTC;
        2:       key = ufp_pkg::ID_STATUS;
        3:       key = ufp_pkg::ID_ACK;
        4:       key = ufp_pkg::ID_NAK;
        default: key = 16'($urandom_range(0, 65535));
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        len = 16'($urandom_range(0, 24));
      end else if (pick < 86) begin
        len = 16'($urandom_range(0, 96));
      end else if (pick < 90) begin
        len = 16'($urandom_range(0, 300));
      end else begin
        // Oversize header: just past the current limit, up to the full 16 bits.
        lo  = (frame_limit < 16'd8) ? 0 : int'(frame_limit) - 7;
        len = 16'($urandom_range(lo, 65535));
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        add_frame(key, len, 0);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 4))
          add_byte(($urandom_range(0, 2) == 0) ? ufp_pkg::SYNC_A
                                               : 8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 96) begin
        add_frame(key, len, $urandom_range(1, 7 + int'(len)));
      end else begin
        add_byte(8'($urandom_range(0, 255)), 1'b1);
      end
    end
  endfunction

  // Hold until every byte has transferred and every predicted frame is out or the wait cap ends.
  task automatic drain_block();
    int waited;
    waited = 0;
    while (byte_backlog.size() != 0 || push) @(posedge clk);
    while (frames_due.size() != 0 && waited < DRAIN_CAP) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // Write a register over the APB-style port, then read the limit back.
  task automatic program_limit(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] seen;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[2] == ufp_pkg::REG_MAX_FRAME_LENGTH) frame_limit = value[15:0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= LIMIT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    seen = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    check_field("max_frame_length readback", seen, {16'h0000, frame_limit});
  endtask

  initial begin
    logic [15:0] lim;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: line noise, repeated sync, zero payload, ACK target, flush, oversize.
    @(negedge clk);
    add_byte(8'hFF, 1'b0);
    add_byte(ufp_pkg::SYNC_A, 1'b0);
    add_frame(ufp_pkg::ID_POSLLH, 16'd0, 0);
    add_frame(ufp_pkg::ID_NAK, 16'd2, 0);
    add_frame(ufp_pkg::ID_ACK, 16'd2, 3);
    add_frame(16'hFFFF, 16'hFFFF, 0);
    drain_block();
    // Index 1 is not a register: the write must leave the limit alone.
    program_limit(SPARE_ADDR, 32'd16);

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0:       lim = 16'd255;
        1:       lim = 16'd8;
        2:       lim = 16'd7;
        3:       lim = 16'd65535;
        4:       lim = 16'($urandom_range(20, 200));
        5:       lim = 16'($urandom_range(8, 40));
        default: lim = ufp_pkg::MAX_LEN_RESET;
      endcase
      if (ph == 3) begin
        send_idle_pct = 73;
        recv_idle_pct = 21;
      end else if (ph == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      program_limit(LIMIT_ADDR, {16'h0000, lim});
      @(negedge clk);
      add_random_traffic(60, 4);
      drain_block();
    end

    if (frames_due.size() != 0)
      log_mismatch($sformatf("%0d predicted frames never came out", frames_due.size()));
    if (mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
